>>> rtl/code39_edge_timing_decoder_macros.svh
// Assertion macros for the checker of the edge-timing Code 39 decoder
`ifndef CODE39_EDGE_TIMING_DECODER_MACROS_SVH
`define CODE39_EDGE_TIMING_DECODER_MACROS_SVH
// implication checked on every clock edge outside reset
`define C39_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("c39 check failed");
// next-cycle implication
`define C39_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("c39 check failed");
`endif

>>> rtl/c39_pkg.sv
// Package: constants, types and Code 39 table for the edge-timing decoder
package c39_pkg;
    localparam int ELEMENTS_PER_CHAR = 9;
    localparam int MAX_CHARS = 100;
    localparam int DUR_W = 32;
    localparam int CNT_W = 7;
    localparam int SYM_W = 6;
    localparam int PAT_W = 9;
    localparam int IDX_W = 4;
    localparam logic [SYM_W-1:0] SYM_UNKNOWN = 6'd44;
    localparam logic [SYM_W-1:0] SYM_STAR = 6'd39;
    localparam int NUM_SYMS = 44;

    localparam logic [1:0] CFG_MAX_ELEM = 2'd0;
    localparam logic [1:0] CFG_END_GAP = 2'd1;
    localparam logic [1:0] CFG_MIN_CHARS = 2'd2;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TIME = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [SYM_W-1:0]        symbol;
        logic [PAT_W-1:0]        pattern;
        logic [DUR_W-1:0]        shortest_us;
        logic [DUR_W-1:0]        longest_us;
        logic [DUR_W-1:0]        split_us;
        logic [CNT_W-1:0]        char_total;
        logic                    framed_ok;
        logic [SYM_W-1:0]        middle_symbol;
        logic                    stored;
    } result_t;

    function automatic logic [PAT_W-1:0] code_of(input logic [5:0] i);
        logic [PAT_W-1:0] c;
        unique case (i)
            6'd0: c = 9'h034;  6'd1: c = 9'h121;  6'd2: c = 9'h061;  6'd3: c = 9'h160;
            6'd4: c = 9'h031;  6'd5: c = 9'h130;  6'd6: c = 9'h070;  6'd7: c = 9'h025;
            6'd8: c = 9'h124;  6'd9: c = 9'h064;  6'd10: c = 9'h109; 6'd11: c = 9'h049;
            6'd12: c = 9'h148; 6'd13: c = 9'h019; 6'd14: c = 9'h118; 6'd15: c = 9'h058;
            6'd16: c = 9'h00D; 6'd17: c = 9'h10C; 6'd18: c = 9'h04C; 6'd19: c = 9'h01C;
            6'd20: c = 9'h103; 6'd21: c = 9'h043; 6'd22: c = 9'h142; 6'd23: c = 9'h013;
            6'd24: c = 9'h112; 6'd25: c = 9'h052; 6'd26: c = 9'h007; 6'd27: c = 9'h106;
            6'd28: c = 9'h046; 6'd29: c = 9'h016; 6'd30: c = 9'h181; 6'd31: c = 9'h0C1;
            6'd32: c = 9'h1C0; 6'd33: c = 9'h091; 6'd34: c = 9'h190; 6'd35: c = 9'h0D0;
            6'd36: c = 9'h085; 6'd37: c = 9'h184; 6'd38: c = 9'h0C4; 6'd39: c = 9'h094;
            6'd40: c = 9'h0A8; 6'd41: c = 9'h0A2; 6'd42: c = 9'h08A; 6'd43: c = 9'h02A;
            default: c = 9'h000;
        endcase
        return c;
    endfunction

    function automatic logic [PAT_W-1:0] reverse9(input logic [PAT_W-1:0] p);
        logic [PAT_W-1:0] r;
        for (int i = 0; i < PAT_W; i++) r[i] = p[PAT_W-1-i];
        return r;
    endfunction

    function automatic logic [SYM_W-1:0] lookup(input logic [PAT_W-1:0] pat);
        logic [SYM_W-1:0] fwd;
        logic [SYM_W-1:0] rev;
        logic [PAT_W-1:0] rp;
        fwd = SYM_UNKNOWN;
        rev = SYM_UNKNOWN;
        rp = reverse9(pat);
        for (int i = NUM_SYMS - 1; i >= 0; i--) begin
            if (code_of(6'(i)) == pat) fwd = 6'(i);
            if (code_of(6'(i)) == rp) rev = 6'(i);
        end
        return (fwd != SYM_UNKNOWN) ? fwd : rev;
    endfunction
endpackage

>>> rtl/c39_dur_ram.sv
// Duration store: nine 32-bit entries, one write and one registered read port
module c39_dur_ram import c39_pkg::*; (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [DUR_W-1:0] wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [DUR_W-1:0] rd_data
);
    logic [DUR_W-1:0] mem [ELEMENTS_PER_CHAR];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

>>> rtl/c39_sym_ram.sv
// First-symbol store: three 6-bit entries, registered read
module c39_sym_ram import c39_pkg::*; (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [1:0]       wr_addr,
    input  logic [SYM_W-1:0] wr_data,
    input  logic [1:0]       rd_addr,
    output logic [SYM_W-1:0] rd_data
);
    logic [SYM_W-1:0] mem [3];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

>>> rtl/code39_edge_timing_decoder.sv
// Top level: edge-timing Code 39 decoder
// Input beats on s_axis: tdata = {black, stamp_us}, tuser = op (0 edge, 1 time check).
// Results on m_axis, at most one per input beat.
// Plain edges are handled in the idle state. The ninth element of a character
// runs a scan of the duration memory: 9 reads for min/max, 9 reads for the
// pattern, then lookup, one read at a time through the single read port. A
// finishing time check reads the symbol memory three times.
// One item is processed at a time; s_tready is low while one is in work
// or while a result waits in the output register.
// Reset (aresetn low, synchronous) returns to waiting for white, clears
// counts and the timer and restores the register defaults. Stored durations
// and symbols are not cleared. A stalled m_tready holds the result and
// blocks new input beats.
module code39_edge_timing_decoder import c39_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [39:0]   s_tdata,   // stamp_us[31:0], black[32], zero pad
    input  logic          s_tuser,   // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // symbol, pattern, shortest, longest, split,
                                     // char_total, framed_ok, middle_symbol, stored
    output logic          m_tuser,   // kind
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIN  = 3'd1;
    localparam logic [2:0] ST_PAT  = 3'd2;
    localparam logic [2:0] ST_LOOK = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;

    localparam logic [1:0] M_WW = 2'd0;
    localparam logic [1:0] M_WB = 2'd1;
    localparam logic [1:0] M_SC = 2'd2;

    logic [DUR_W-1:0] max_elem_reg, end_gap_reg;
    logic [CNT_W-1:0] min_chars_reg;
    logic [2:0] st_reg;
    logic [1:0] mode_reg;
    logic [IDX_W-1:0] eidx_reg;
    logic [DUR_W-1:0] last_reg, white_reg;
    logic [CNT_W-1:0] good_reg, all_reg;
    logic [IDX_W:0] cnt_reg;
    logic [DUR_W-1:0] lo_reg, hi_reg, split_reg;
    logic [PAT_W-1:0] pat_reg;
    logic out_v_reg;
    result_t res_reg;

    logic d_we;
    logic [IDX_W-1:0] d_wa, d_ra;
    logic [DUR_W-1:0] d_wd, d_rd;
    logic s_we;
    logic [1:0] s_wa, s_ra;
    logic [SYM_W-1:0] s_wd, s_rd;

    logic acc;
    logic [DUR_W-1:0] stamp, dur;
    logic blk;
    logic rd_valid;
    logic [SYM_W-1:0] sym;

    assign stamp = s_tdata[31:0];
    assign blk = s_tdata[32];
    assign dur = stamp - last_reg;
    assign s_tready = (st_reg == ST_IDLE) && !out_v_reg;
    assign acc = s_tvalid && s_tready;
    assign rd_valid = (cnt_reg != '0);
    assign sym = lookup(pat_reg);

    c39_dur_ram u_dur (.aclk, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
                       .rd_addr(d_ra), .rd_data(d_rd));
    c39_sym_ram u_sym (.aclk, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
                       .rd_addr(s_ra), .rd_data(s_rd));

    assign d_we = acc && s_tuser == OP_EDGE && mode_reg == M_SC && !(dur > max_elem_reg);
    assign d_wa = eidx_reg;
    assign d_wd = dur;
    assign d_ra = cnt_reg[IDX_W-1:0];
    assign s_we = (st_reg == ST_LOOK) && all_reg < CNT_W'(3);
    assign s_wa = all_reg[1:0];
    assign s_wd = sym;
    assign s_ra = (st_reg != ST_END || cnt_reg == '0) ? 2'd0 :
                  (cnt_reg == (IDX_W+1)'(1)) ? 2'd2 : 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_elem_reg <= 32'd500000;
            end_gap_reg <= 32'd300000;
            min_chars_reg <= CNT_W'(3);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_ELEM: max_elem_reg <= cfg_data;
                CFG_END_GAP: end_gap_reg <= cfg_data;
                CFG_MIN_CHARS: min_chars_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            mode_reg <= M_WW;
            eidx_reg <= '0;
            last_reg <= '0;
            white_reg <= '0;
            good_reg <= '0;
            all_reg <= '0;
            cnt_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (acc && s_tuser == OP_TIME) begin
                        if (good_reg >= min_chars_reg && white_reg != '0 &&
                            (stamp - white_reg) > end_gap_reg) begin
                            st_reg <= ST_END;
                            cnt_reg <= '0;
                        end
                    end else if (acc) begin
                        if (mode_reg != M_SC) begin
                            if (good_reg != '0 && !blk && white_reg == '0)
                                white_reg <= stamp;
                            if (blk) white_reg <= '0;
                        end
                        unique case (mode_reg)
                            M_WW: if (!blk) begin
                                mode_reg <= M_WB;
                                last_reg <= stamp;
                            end
                            M_WB: if (blk) begin
                                mode_reg <= M_SC;
                                eidx_reg <= '0;
                                last_reg <= stamp;
                            end
                            M_SC: begin
                                if (dur > max_elem_reg) begin
                                    mode_reg <= M_WW;
                                end else begin
                                    last_reg <= stamp;
                                    if (eidx_reg == IDX_W'(ELEMENTS_PER_CHAR - 1)) begin
                                        eidx_reg <= '0;
                                        st_reg <= ST_MIN;
                                        cnt_reg <= '0;
                                        lo_reg <= '1;
                                        hi_reg <= '0;
                                    end else begin
                                        eidx_reg <= eidx_reg + 1'b1;
                                    end
                                end
                            end
                            default: mode_reg <= M_WW;
                        endcase
                    end
                end
                ST_MIN: begin
                    if (rd_valid) begin
                        if (d_rd < lo_reg) lo_reg <= d_rd;
                        if (d_rd > hi_reg) hi_reg <= d_rd;
                    end
                    if (cnt_reg == (IDX_W+1)'(ELEMENTS_PER_CHAR)) begin
                        st_reg <= ST_PAT;
                        cnt_reg <= '0;
                        pat_reg <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_PAT: begin
                    if (!rd_valid) split_reg <= lo_reg + ((hi_reg - lo_reg) >> 1);
                    else pat_reg <= {pat_reg[PAT_W-2:0], d_rd > split_reg};
                    if (cnt_reg == (IDX_W+1)'(ELEMENTS_PER_CHAR)) st_reg <= ST_LOOK;
                    else cnt_reg <= cnt_reg + 1'b1;
                end
                ST_LOOK: begin
                    res_reg <= '{kind: KIND_CHAR, symbol: sym, pattern: pat_reg,
                                 shortest_us: lo_reg, longest_us: hi_reg,
                                 split_us: split_reg,
                                 char_total: (all_reg < CNT_W'(MAX_CHARS)) ?
                                             all_reg + 1'b1 : all_reg,
                                 framed_ok: 1'b0, middle_symbol: '0, stored: 1'b0};
                    if (all_reg < CNT_W'(MAX_CHARS)) all_reg <= all_reg + 1'b1;
                    if (sym != SYM_UNKNOWN && good_reg < CNT_W'(MAX_CHARS - 1))
                        good_reg <= good_reg + 1'b1;
                    out_v_reg <= 1'b1;
                    st_reg <= ST_IDLE;
                end
                ST_END: begin
                    // reads entries 0, 2, 1 in turn; each read lands in the next cycle
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (IDX_W+1)'(1)) lo_reg[SYM_W-1:0] <= s_rd;
                    if (cnt_reg == (IDX_W+1)'(2)) begin
                        res_reg <= '{kind: KIND_END, symbol: '0, pattern: '0,
                                     shortest_us: '0, longest_us: '0, split_us: '0,
                                     char_total: all_reg,
                                     framed_ok: all_reg == CNT_W'(3) &&
                                                lo_reg[SYM_W-1:0] == SYM_STAR &&
                                                s_rd == SYM_STAR,
                                     middle_symbol: '0, stored: all_reg == CNT_W'(3)};
                    end
                    if (cnt_reg == (IDX_W+1)'(3)) begin
                        if (all_reg >= CNT_W'(2)) res_reg.middle_symbol <= s_rd;
                        good_reg <= '0;
                        all_reg <= '0;
                        white_reg <= '0;
                        mode_reg <= M_WW;
                        out_v_reg <= 1'b1;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser = res_reg.kind;
    assign m_tdata = {2'd0, res_reg.stored, res_reg.middle_symbol, res_reg.framed_ok,
                      res_reg.char_total, res_reg.split_us, res_reg.longest_us,
                      res_reg.shortest_us, res_reg.pattern, res_reg.symbol};
endmodule

>>> rtl/c39_checker.sv
// Port-level checker for the decoder, bound to the top level
`include "code39_edge_timing_decoder_macros.svh"
module c39_checker import c39_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);
    `C39_ASSERT_IMP(a_no_in_while_out, aclk, aresetn, m_tvalid, !s_tready)
    `C39_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `C39_ASSERT_IMP(a_sym_range, aclk, aresetn, m_tvalid && m_tuser == KIND_CHAR,
                    m_tdata[5:0] <= SYM_UNKNOWN)
    `C39_ASSERT_IMP(a_end_zero, aclk, aresetn, m_tvalid && m_tuser == KIND_END,
                    m_tdata[14:0] == 15'd0)
endmodule

bind code39_edge_timing_decoder c39_checker u_c39_checker (.*);

>>> sim/tb_code39_edge_timing_decoder.sv
// Testbench for the edge-timing Code 39 decoder: stream stimulus, in-bench predictor, scoreboard
`timescale 1ns / 1ps

module tb_code39_edge_timing_decoder;
    import c39_pkg::*;

    localparam logic [8:0] CODE_TAB [44] = '{
        9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
        9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
        9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
        9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0,
        9'h085, 9'h184, 9'h0C4, 9'h094, 9'h0A8, 9'h0A2, 9'h08A, 9'h02A
    };
    localparam logic [1:0] M_WAIT_WHITE = 2'd0;
    localparam logic [1:0] M_WAIT_BLACK = 2'd1;
    localparam logic [1:0] M_SCAN = 2'd2;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    code39_edge_timing_decoder u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0] max_elem, end_gap;
    logic [6:0]  min_chars;
    logic [1:0]  mode;
    logic [3:0]  elem_idx;
    logic [31:0] last_edge, white_start;
    logic [31:0] durations [9];
    logic [6:0]  good_cnt, all_cnt;
    logic [5:0]  first_syms [3];

    result_t expected_q [$];
    int          mismatches;
    int          burst_left;
    logic [31:0] now_us;
    int          stall_mode;
    int          stall_left;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("tb_code39_edge_timing_decoder: FAIL");
        $finish;
    end

    function automatic logic [5:0] find_symbol(input logic [8:0] pat);
        logic [8:0] rev;
        for (int i = 0; i < 9; i++) rev[i] = pat[8-i];
        for (int i = 0; i < 44; i++) if (CODE_TAB[i] == pat) return 6'(i);
        for (int i = 0; i < 44; i++) if (CODE_TAB[i] == rev) return 6'(i);
        return SYM_UNKNOWN;
    endfunction

    task automatic predict_beat(input logic op, input logic [31:0] stamp, input logic blk);
        result_t r;
        logic [31:0] dur, lo, hi, split;
        logic [8:0]  pat;
        logic [5:0]  sym;
        r = '0;
        if (op == OP_TIME) begin
            if (good_cnt >= min_chars && white_start != 0 && (stamp - white_start) > end_gap) begin
                r.kind = KIND_END;
                r.char_total = all_cnt;
                r.framed_ok = (all_cnt == 3 && first_syms[0] == SYM_STAR
                               && first_syms[2] == SYM_STAR);
                r.middle_symbol = (all_cnt >= 2) ? first_syms[1] : 6'd0;
                r.stored = (all_cnt == 3);
                good_cnt = 0;
                all_cnt = 0;
                white_start = 0;
                mode = M_WAIT_WHITE;
                expected_q.push_back(r);
            end
            return;
        end
        if (mode != M_SCAN) begin
            if (good_cnt > 0 && !blk && white_start == 0) white_start = stamp;
            if (blk && white_start != 0) white_start = 0;
        end
        case (mode)
            M_WAIT_WHITE: begin
                if (!blk) begin
                    mode = M_WAIT_BLACK;
                    last_edge = stamp;
                end
            end
            M_WAIT_BLACK: begin
                if (blk) begin
                    elem_idx = 0;
                    last_edge = stamp;
                    mode = M_SCAN;
                end
            end
            default: begin
                dur = stamp - last_edge;
                if (dur > max_elem) begin
                    mode = M_WAIT_WHITE;
                    return;
                end
                durations[elem_idx] = dur;
                elem_idx++;
                last_edge = stamp;
                if (elem_idx != 9) return;
                lo = '1;
                hi = '0;
                for (int i = 0; i < 9; i++) begin
                    if (durations[i] < lo) lo = durations[i];
                    if (durations[i] > hi) hi = durations[i];
                end
                split = lo + (hi - lo) / 2;
                for (int i = 0; i < 9; i++) pat[8-i] = durations[i] > split;
                sym = find_symbol(pat);
                if (all_cnt < MAX_CHARS) begin
                    if (all_cnt < 3) first_syms[all_cnt] = sym;
                    all_cnt++;
                end
                if (sym != SYM_UNKNOWN && good_cnt < MAX_CHARS - 1) good_cnt++;
                elem_idx = 0;
                r.kind = KIND_CHAR;
                r.symbol = sym;
                r.pattern = pat;
                r.shortest_us = lo;
                r.longest_us = hi;
                r.split_us = split;
                r.char_total = all_cnt;
                expected_q.push_back(r);
            end
        endcase
    endtask

    task automatic send_beat(input logic op, input logic [31:0] stamp, input logic blk);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, blk, stamp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_beat(op, stamp, blk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_ELEM: max_elem = val;
            CFG_END_GAP: end_gap = val;
            default: min_chars = val[6:0];
        endcase
    endtask

    task automatic edge_at(input logic blk);
        send_beat(OP_EDGE, now_us, blk);
    endtask

    // white then black: enters scanning
    task automatic open_scan(input logic [31:0] lead);
        edge_at(1'b0);
        now_us += lead;
        edge_at(1'b1);
    endtask

    task automatic send_char(input logic [8:0] pat, input logic [31:0] n, input logic [31:0] w);
        for (int i = 8; i >= 0; i--) begin
            now_us += pat[i] ? w : n;
            edge_at(i[0]);
        end
    endtask

    // over-long element, white edge, a time check inside the gap, then one after the gap
    task automatic close_scan(input logic [31:0] extra);
        now_us += max_elem + 1 + extra;
        edge_at(1'b1);
        now_us += $urandom_range(1, 50);
        edge_at(1'b0);
        send_beat(OP_TIME, now_us + end_gap / 2, 1'b0);
        send_beat(OP_TIME, now_us + end_gap + 1 + $urandom_range(0, 20), 1'b0);
    endtask

    task automatic test_directed();
        now_us = 32'd0;
        open_scan(32'd100);
        send_char(CODE_TAB[SYM_STAR], 32'd100, 32'd300);
        send_char(CODE_TAB[10], 32'd100, 32'd300);
        send_char(9'h000, 32'd100, 32'd300);
        send_beat(OP_TIME, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_EDGE, 32'd0, 1'b0);
        now_us = 32'hFFFF_FF00;
        open_scan(32'd50);
        send_char(CODE_TAB[SYM_STAR], 32'd100, 32'd250);
        send_char(CODE_TAB[5], 32'd100, 32'd250);
        send_char(CODE_TAB[SYM_STAR], 32'd100, 32'd250);
        close_scan(32'd0);
        now_us = 32'hFFFF_FFF0;
        open_scan(32'd1);
        send_char(9'h052 ^ 9'h000, 32'd0, 32'd7);
        close_scan(32'd3);
    endtask

    task automatic test_saturation();
        write_reg(CFG_MIN_CHARS, 32'd99);
        now_us = $urandom;
        open_scan(32'd40);
        for (int c = 0; c < 101; c++) send_char(CODE_TAB[$urandom_range(0, 43)], 32'd20, 32'd60);
        close_scan(32'd5);
    endtask

    task automatic random_barcode();
        int nchar;
        logic [31:0] n, w;
        logic [8:0] pat;
        n = $urandom_range(1, 3000);
        w = n * $urandom_range(2, 3) + $urandom_range(0, 5);
        if (w > max_elem) begin
            w = max_elem;
            n = (max_elem > 2) ? max_elem / 3 : 0;
        end
        nchar = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 3;
        open_scan($urandom_range(1, 1000));
        for (int c = 0; c < nchar; c++) begin
            case ($urandom_range(0, 9))
                0: pat = 9'($urandom);
                1: pat = CODE_TAB[$urandom_range(0, 43)];
                2: begin
                    pat = CODE_TAB[$urandom_range(0, 43)];
                    for (int i = 0; i < 9; i++) pat[i] = CODE_TAB[0][0] ^ pat[i] ^ pat[8-i] ^ pat[i];
                end
                default: pat = (nchar == 3 && c != 1) ? CODE_TAB[SYM_STAR]
                                                       : CODE_TAB[$urandom_range(0, 43)];
            endcase
            send_char(pat, n, w);
        end
        if ($urandom_range(0, 5) == 0) begin
            now_us += $urandom_range(0, 2) == 0 ? max_elem + 1 : n;
            edge_at(1'($urandom_range(0, 1)));
        end
        if (max_elem < 32'hFFFF_0000) close_scan($urandom_range(0, 1000));
    endtask

    task automatic random_noise();
        int k;
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 3) == 0) now_us = $urandom;
            else now_us += $urandom_range(0, 100000);
            send_beat(1'($urandom_range(0, 1)), now_us, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random(input int beats);
        int start;
        start = 0;
        while (start < beats) begin
            if ($urandom_range(0, 7) == 0) begin
                random_noise();
                start += 4;
            end else begin
                random_barcode();
                start += 35;
            end
        end
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_MAX_ELEM, 32'd1);
        write_reg(CFG_END_GAP, 32'd1);
        write_reg(CFG_MIN_CHARS, 32'd1);
        test_random(40);
        write_reg(CFG_END_GAP, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_ELEM, 32'hFFFF_FFFF);
        test_random(30);
        write_reg(CFG_MAX_ELEM, 32'd5000);
        write_reg(CFG_END_GAP, 32'd20000);
        write_reg(CFG_MIN_CHARS, 32'd2);
        test_random(60);
        write_reg(CFG_MAX_ELEM, $urandom_range(4000, 1 << 20));
        write_reg(CFG_END_GAP, $urandom);
        write_reg(CFG_END_GAP, $urandom_range(1, 1 << 22));
        write_reg(CFG_MIN_CHARS, 32'd3);
        test_random(70);
    endtask

    // receiver: stall pattern switches between free-flowing, random and mostly-stalled
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.symbol = m_tdata[5:0];
            got.pattern = m_tdata[14:6];
            got.shortest_us = m_tdata[46:15];
            got.longest_us = m_tdata[78:47];
            got.split_us = m_tdata[110:79];
            got.char_total = m_tdata[117:111];
            got.framed_ok = m_tdata[118];
            got.middle_symbol = m_tdata[124:119];
            got.stored = m_tdata[125];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got.kind !== want.kind || got.symbol !== want.symbol
                    || got.pattern !== want.pattern || got.shortest_us !== want.shortest_us
                    || got.longest_us !== want.longest_us || got.split_us !== want.split_us
                    || got.char_total !== want.char_total
                    || got.framed_ok !== want.framed_ok
                    || got.middle_symbol !== want.middle_symbol
                    || got.stored !== want.stored) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MAX_ELEM;
        cfg_data = '0;
        mismatches = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        max_elem = 32'd500000;
        end_gap = 32'd300000;
        min_chars = 7'd3;
        mode = M_WAIT_WHITE;
        elem_idx = 0;
        last_edge = 0;
        white_start = 0;
        good_cnt = 0;
        all_cnt = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_saturation();
        test_config_extremes();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb_code39_edge_timing_decoder: PASS");
        end else begin
            $display("tb_code39_edge_timing_decoder: FAIL");
        end
        $finish;
    end
endmodule
